@@ rtl/core/cpid_pkg.sv @@
// ----------------------------------------------------------------------------
// cpid_pkg
// shared types, register indexes and fixed-point helpers of the cascade pid
// ----------------------------------------------------------------------------
package cpid_pkg;

   localparam int AccW = 48;   // wide accumulator of the inner and outer sums
   localparam int ErrW = 28;   // inner error width
   localparam int IntW = 18;   // integral width
   localparam int NumW = 33;   // derivative numerator magnitude width

   localparam logic [2:0] REG_OUTER_KP     = 3'd0;
   localparam logic [2:0] REG_OUTER_KI     = 3'd1;
   localparam logic [2:0] REG_INNER_KP     = 3'd2;
   localparam logic [2:0] REG_INNER_KI     = 3'd3;
   localparam logic [2:0] REG_INNER_KD     = 3'd4;
   localparam logic [2:0] REG_OUTPUT_LIMIT = 3'd5;

   localparam logic signed [ErrW-1:0] OuterSep   = 28'sd1600;
   localparam logic signed [ErrW-1:0] InnerSep   = 28'sd6400;
   localparam logic signed [ErrW:0]   OuterClamp = 29'sd48000;
   localparam logic signed [ErrW:0]   InnerClamp = 29'sd24000;

   typedef struct packed {
      logic busy;
      logic done;
   } cpid_stat_type;

   // integral separation followed by the symmetric clamp
   function automatic logic signed [IntW-1:0] separate(
      input logic signed [IntW-1:0] integ,
      input logic signed [ErrW-1:0] err,
      input logic signed [ErrW-1:0] sep,
      input logic signed [ErrW:0]   lim
   );
      logic signed [ErrW-1:0] mag;
      logic signed [ErrW:0]   t;
      mag = err[ErrW-1] ? -err : err;
      if (mag < sep) begin
         t = ErrW'(integ) + err;
      end else begin
         t = '0;
      end
      if (t > lim) begin
         t = lim;
      end else if (t < -lim) begin
         t = -lim;
      end
      return IntW'(t);
   endfunction

endpackage

@@ rtl/core/cascade_pid_pitch_dual_integral.sv @@
// ----------------------------------------------------------------------------
// cascade_pid_pitch_dual_integral
// outer pi position loop feeding an inner pid rate loop for one gimbal axis
// ----------------------------------------------------------------------------
// usage:
//   req_ carries one sample (position, goal, rate, elapsed ticks) per item;
//   rsp_ returns one drive command per sample, in order.
//   csr_ writes gains and the output limit; write only while the block idles.
// sequencing:
//   one sample at a time. five products go through one bit-serial multiplier;
//   a nonzero tick count adds a restoring divide. a new sample is accepted
//   only after the result of the previous one is loaded into the output
//   register.
// reset:
//   gains and limit return to their defaults, both integrals and the stored
//   rate clear, no result is pending.
// stall:
//   the result sits in an output register; the next item is accepted while
//   it waits, and its own result holds until the register is free.
// ----------------------------------------------------------------------------
module cascade_pid_pitch_dual_integral (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // position_now, position_goal, rate_now, elapsed_ticks
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // drive_value
   output logic [15:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   typedef enum logic [9:0] {
      ST_IDLE    = 10'b0000000001,
      ST_OUTER   = 10'b0000000010,
      ST_MUL_OKP = 10'b0000000100,
      ST_MUL_OKI = 10'b0000001000,
      ST_INNER   = 10'b0000010000,
      ST_MUL_IKP = 10'b0000100000,
      ST_MUL_IKI = 10'b0001000000,
      ST_MUL_IKD = 10'b0010000000,
      ST_DIV     = 10'b0100000000,
      ST_OUT     = 10'b1000000000
   } state_type;

   localparam int AccW = cpid_pkg::AccW;
   localparam int ErrW = cpid_pkg::ErrW;
   localparam int IntW = cpid_pkg::IntW;
   localparam int NumW = cpid_pkg::NumW;

   state_type state_ff, state_in;

   logic signed [15:0] okp_ff, oki_ff, ikp_ff, iki_ff, ikd_ff;
   logic [14:0]        lim_ff;

   logic signed [15:0] pnow_ff, pnow_in, pgoal_ff, pgoal_in, rate_ff, rate_in;
   logic [15:0]        ticks_ff, ticks_in;
   logic signed [IntW-1:0] oint_ff, oint_in, iint_ff, iint_in;
   logic signed [15:0] prev_ff, prev_in;
   logic signed [AccW-1:0] sum_ff, sum_in;
   logic               dneg_ff, dneg_in;
   logic               rvalid_ff, rvalid_in;
   logic signed [15:0] rdata_ff, rdata_in;

   logic                   mstart;
   logic signed [AccW-1:0] ma, mprod, pmag, qext, rt_full, drv_full, lim_ext;
   logic signed [15:0]     mb;
   cpid_pkg::cpid_stat_type mstat, dstat;
   logic                   dstart;
   logic [NumW-1:0]        quot;
   logic signed [ErrW-1:0] erro;

   cpid_smul u_mul (
      .clock (clock), .reset (reset), .start (mstart),
      .mcand (ma), .mplier (mb), .prod (mprod), .stat (mstat)
   );

   cpid_sdiv u_div (
      .clock (clock), .reset (reset), .start (dstart),
      .num (pmag[NumW-1:0]), .den (ticks_ff), .quot (quot), .stat (dstat)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign erro = ErrW'(pgoal_ff) - ErrW'(pnow_ff);
   assign pmag = mprod[AccW-1] ? -mprod : mprod;
   assign qext = dneg_ff ? -AccW'($signed({1'b0, quot})) : AccW'($signed({1'b0, quot}));
   assign rt_full  = (sum_ff + AccW'(128)) >>> 8;
   assign drv_full = (sum_ff + AccW'(2048)) >>> 12;
   assign lim_ext  = AccW'($signed({1'b0, lim_ff}));

   always_comb begin
      state_in  = state_ff;
      pnow_in   = pnow_ff;
      pgoal_in  = pgoal_ff;
      rate_in   = rate_ff;
      ticks_in  = ticks_ff;
      oint_in   = oint_ff;
      iint_in   = iint_ff;
      prev_in   = prev_ff;
      sum_in    = sum_ff;
      dneg_in   = dneg_ff;
      rvalid_in = rvalid_ff && !rsp_tready;
      rdata_in  = rdata_ff;
      mstart    = 1'b0;
      ma        = '0;
      mb        = '0;
      dstart    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               pnow_in  = req_tdata[15:0];
               pgoal_in = req_tdata[31:16];
               rate_in  = req_tdata[47:32];
               ticks_in = req_tdata[63:48];
               state_in = ST_OUTER;
            end
         end
         ST_OUTER: begin
            oint_in  = cpid_pkg::separate(oint_ff, erro, cpid_pkg::OuterSep,
                                          cpid_pkg::OuterClamp);
            sum_in   = '0;
            mstart   = 1'b1;
            ma       = AccW'(erro);
            mb       = okp_ff;
            state_in = ST_MUL_OKP;
         end
         ST_MUL_OKP: begin
            if (mstat.done) begin
               sum_in   = sum_ff + mprod;
               mstart   = 1'b1;
               ma       = AccW'(oint_ff);
               mb       = oki_ff;
               state_in = ST_MUL_OKI;
            end
         end
         ST_MUL_OKI: begin
            if (mstat.done) begin
               sum_in   = sum_ff + mprod;
               state_in = ST_INNER;
            end
         end
         ST_INNER: begin
            // rate target rounded to q12.4, then the inner error
            iint_in  = cpid_pkg::separate(iint_ff, ErrW'(rt_full) - ErrW'(rate_ff),
                                          cpid_pkg::InnerSep, cpid_pkg::InnerClamp);
            sum_in   = '0;
            mstart   = 1'b1;
            ma       = AccW'(ErrW'(rt_full) - ErrW'(rate_ff));
            mb       = ikp_ff;
            state_in = ST_MUL_IKP;
         end
         ST_MUL_IKP: begin
            if (mstat.done) begin
               sum_in   = sum_ff + mprod;
               mstart   = 1'b1;
               ma       = AccW'(iint_ff);
               mb       = iki_ff;
               state_in = ST_MUL_IKI;
            end
         end
         ST_MUL_IKI: begin
            if (mstat.done) begin
               sum_in   = sum_ff + mprod;
               mstart   = 1'b1;
               ma       = AccW'(prev_ff) - AccW'(rate_ff);
               mb       = ikd_ff;
               prev_in  = rate_ff;
               state_in = ST_MUL_IKD;
            end
         end
         ST_MUL_IKD: begin
            if (mstat.done) begin
               if (ticks_ff == '0) begin
                  state_in = ST_OUT;
               end else begin
                  dstart   = 1'b1;
                  dneg_in  = mprod[AccW-1];
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (dstat.done) begin
               sum_in   = sum_ff + qext;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rvalid_ff || rsp_tready) begin
               if (drv_full > lim_ext) begin
                  rdata_in = 16'(lim_ff);
               end else if (drv_full < -lim_ext) begin
                  rdata_in = -16'(lim_ff);
               end else begin
                  rdata_in = drv_full[15:0];
               end
               rvalid_in = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      pnow_in_reg: begin
         pnow_ff  <= pnow_in;
         pgoal_ff <= pgoal_in;
         rate_ff  <= rate_in;
         ticks_ff <= ticks_in;
         sum_ff   <= sum_in;
         dneg_ff  <= dneg_in;
         rdata_ff <= rdata_in;
      end
      if (reset) begin
         state_ff  <= ST_IDLE;
         rvalid_ff <= 1'b0;
         oint_ff   <= '0;
         iint_ff   <= '0;
         prev_ff   <= '0;
         okp_ff    <= -16'sd3840;
         oki_ff    <= -16'sd102;
         ikp_ff    <= -16'sd1664;
         iki_ff    <= '0;
         ikd_ff    <= '0;
         lim_ff    <= 15'd3000;
      end else begin
         state_ff  <= state_in;
         rvalid_ff <= rvalid_in;
         oint_ff   <= oint_in;
         iint_ff   <= iint_in;
         prev_ff   <= prev_in;
         if (csr_we) begin
            case (csr_addr)
               cpid_pkg::REG_OUTER_KP:     okp_ff <= csr_wdata;
               cpid_pkg::REG_OUTER_KI:     oki_ff <= csr_wdata;
               cpid_pkg::REG_INNER_KP:     ikp_ff <= csr_wdata;
               cpid_pkg::REG_INNER_KI:     iki_ff <= csr_wdata;
               cpid_pkg::REG_INNER_KD:     ikd_ff <= csr_wdata;
               cpid_pkg::REG_OUTPUT_LIMIT: lim_ff <= csr_wdata[14:0];
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rdata_ff;

   // the multiplier is never restarted while a product is in flight
   a_mul_free: assert property (@(posedge clock) disable iff (reset)
      mstart |-> !mstat.busy) else $error("multiplier restarted while busy");

   // the divider only runs while the sequencer waits on it
   a_div_state: assert property (@(posedge clock) disable iff (reset)
      dstat.busy |-> (state_ff == ST_DIV)) else $error("divider busy outside divide");

   // a pending drive stays within the configured limit
   a_drive_lim: assert property (@(posedge clock) disable iff (reset)
      rvalid_ff |-> ($signed(rdata_ff) <= $signed({1'b0, lim_ff}) &&
                     $signed(rdata_ff) >= -$signed({1'b0, lim_ff})))
      else $error("drive outside limit");

   // integrals stay inside their clamps
   a_int_clamp: assert property (@(posedge clock) disable iff (reset)
      (oint_ff <= 18'sd48000 && oint_ff >= -18'sd48000 &&
       iint_ff <= 18'sd24000 && iint_ff >= -18'sd24000))
      else $error("integral outside clamp");

endmodule

@@ rtl/core/cpid_smul.sv @@
// ----------------------------------------------------------------------------
// cpid_smul
// bit-serial signed multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module cpid_smul (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [cpid_pkg::AccW-1:0]   mcand,
   input  logic signed [15:0]                 mplier,
   output logic signed [cpid_pkg::AccW-1:0]   prod,
   output cpid_pkg::cpid_stat_type            stat
);

   logic signed [cpid_pkg::AccW-1:0] mcand_ff, mcand_in, acc_ff, acc_in;
   logic [15:0] mplier_ff, mplier_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         mcand_in  = mcand;
         mplier_in = mplier;
         acc_in    = '0;
         cnt_in    = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         // the top bit of the multiplier carries negative weight
         if (mplier_ff[0]) begin
            acc_in = (cnt_ff == 4'd15) ? acc_ff - mcand_ff : acc_ff + mcand_ff;
         end
         mcand_in  = mcand_ff <<< 1;
         mplier_in = {1'b0, mplier_ff[15:1]};
         cnt_in    = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      cnt_ff    <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign prod      = acc_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

@@ rtl/core/cpid_sdiv.sv @@
// ----------------------------------------------------------------------------
// cpid_sdiv
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module cpid_sdiv (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [cpid_pkg::NumW-1:0]     num,
   input  logic [15:0]                   den,
   output logic [cpid_pkg::NumW-1:0]     quot,
   output cpid_pkg::cpid_stat_type       stat
);

   logic [cpid_pkg::NumW-1:0] quo_ff, quo_in;
   logic [15:0] rem_ff, rem_in, den_ff, den_in;
   logic [16:0] shifted;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[cpid_pkg::NumW-1]};
      if (start) begin
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = 16'(shifted - {1'b0, den_ff});
            quo_in = {quo_ff[cpid_pkg::NumW-2:0], 1'b1};
         end else begin
            rem_in = shifted[15:0];
            quo_in = {quo_ff[cpid_pkg::NumW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(cpid_pkg::NumW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quot      = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Checks the cascade pitch pid one drive command per sample. A behavioral
// model of both loops predicts each drive value. Samples and responses move
// with random gaps and stalls, and the gains are changed between phases.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        csr_we;
   logic [2:0]  csr_addr;
   logic [15:0] csr_wdata;

   cascade_pid_pitch_dual_integral DUT (.*);

   // gains and limit held by the predictor
   longint g_okp, g_oki, g_ikp, g_iki, g_ikd, g_lim;
   longint outer_acc, inner_acc, last_rate;

   logic [63:0] sample_queue[$];
   logic [15:0] drive_queue[$];
   int          mismatches;
   bit          quiet;   // no idling on either side
   bit          req_taken;   // offered item was accepted at the last edge

   function automatic longint shift_round(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint limit_to(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic longint accumulate(longint acc, longint err, longint sep,
                                         longint lim);
      longint mag;
      mag = err < 0 ? -err : err;
      return limit_to(mag < sep ? acc + err : 0, lim);
   endfunction

   function automatic logic [15:0] predict_drive(logic [63:0] s);
      longint pn, pg, rt, tk, eo, target, ei, dv, sum;
      pn = longint'($signed(s[15:0]));
      pg = longint'($signed(s[31:16]));
      rt = longint'($signed(s[47:32]));
      tk = longint'(s[63:48]);
      eo = pg - pn;
      outer_acc = accumulate(outer_acc, eo, 1600, 48000);
      target = shift_round(eo * g_okp + outer_acc * g_oki, 8);
      ei = target - rt;
      inner_acc = accumulate(inner_acc, ei, 6400, 24000);
      dv = 0;
      if (tk != 0) dv = ((last_rate - rt) * g_ikd) / tk;
      sum = ei * g_ikp + inner_acc * g_iki + dv;
      last_rate = rt;
      return 16'(limit_to(shift_round(sum, 12), g_lim));
   endfunction

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // hold the offered item
      end else if (sample_queue.size() > 0 && (quiet || $urandom_range(99) >= 21)) begin
         req_tvalid <= 1'b1;
         req_tdata  <= sample_queue[0];
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   always @(posedge clock) begin
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         void'(sample_queue.pop_front());
         drive_queue.push_back(predict_drive(req_tdata));
      end
   end

   always @(negedge clock) begin
      rsp_tready <= reset ? 1'b0 : (quiet || $urandom_range(99) >= 21);
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (drive_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected drive %0d", $signed(rsp_tdata));
         end else begin
            if (rsp_tdata !== drive_queue[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("drive_value expected %0d got %0d",
                           $signed(drive_queue[0]), $signed(rsp_tdata));
            end
            void'(drive_queue.pop_front());
         end
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         cpid_pkg::REG_OUTER_KP:     g_okp = longint'($signed(val));
         cpid_pkg::REG_OUTER_KI:     g_oki = longint'($signed(val));
         cpid_pkg::REG_INNER_KP:     g_ikp = longint'($signed(val));
         cpid_pkg::REG_INNER_KI:     g_iki = longint'($signed(val));
         cpid_pkg::REG_INNER_KD:     g_ikd = longint'($signed(val));
         cpid_pkg::REG_OUTPUT_LIMIT: g_lim = longint'(val[14:0]);
         default: ;
      endcase
   endtask

   task automatic drain();
      while (sample_queue.size() > 0 || drive_queue.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic logic [15:0] near(int span);
      return 16'($signed(16'($urandom_range(2 * span))) - span);
   endfunction

   // small errors keep both integrals busy; the rest is wide noise
   function automatic logic [63:0] random_sample();
      logic [15:0] pn, pg, rt, tk;
      int k;
      k = $urandom_range(99);
      pn = 16'($urandom);
      pg = (k < 60) ? pn + near(120) : 16'($urandom);
      rt = (k < 50) ? near(800) : 16'($urandom);
      tk = ($urandom_range(9) == 0) ? 16'd0 :
           ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 8));
      return {tk, rt, pg, pn};
   endfunction

   task automatic phase(int n);
      repeat (n) sample_queue.push_back(random_sample());
      drain();
   endtask

   task automatic random_gains(int kdscale);
      write_reg(cpid_pkg::REG_OUTER_KP, near(4000));
      write_reg(cpid_pkg::REG_OUTER_KI, near(300));
      write_reg(cpid_pkg::REG_INNER_KP, near(2000));
      write_reg(cpid_pkg::REG_INNER_KI, near(200));
      write_reg(cpid_pkg::REG_INNER_KD, near(kdscale));
      write_reg(cpid_pkg::REG_OUTPUT_LIMIT, 16'($urandom_range(32767)));
   endtask

   initial begin
      reset = 1'b1; quiet = 1'b0; mismatches = 0;
      csr_we = 1'b0; csr_addr = '0; csr_wdata = '0;
      g_okp = -3840; g_oki = -102; g_ikp = -1664; g_iki = 0; g_ikd = 0; g_lim = 3000;
      outer_acc = 0; inner_acc = 0; last_rate = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: field extremes, separation edges, zero ticks, default gains, then extreme gains and limits
      sample_queue.push_back({16'd0, 16'd0, 16'd0, 16'd0});
      sample_queue.push_back({16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h8000});
      sample_queue.push_back({16'd0, 16'h8000, 16'h8000, 16'h7FFF});
      sample_queue.push_back({16'd1, 16'h7FFF, 16'd1599, 16'd0});
      sample_queue.push_back({16'd1, 16'h0000, 16'd1600, 16'd0});
      sample_queue.push_back({16'd0, 16'h0000, 16'hF9C1, 16'd0});
      repeat (6) sample_queue.push_back({16'd1, 16'h0010, 16'd1500, 16'd0});
      drain();
      write_reg(cpid_pkg::REG_OUTER_KP, 16'h7FFF);
      write_reg(cpid_pkg::REG_OUTER_KI, 16'h7FFF);
      write_reg(cpid_pkg::REG_INNER_KP, 16'h7FFF);
      write_reg(cpid_pkg::REG_INNER_KI, 16'h7FFF);
      write_reg(cpid_pkg::REG_INNER_KD, 16'h7FFF);
      write_reg(cpid_pkg::REG_OUTPUT_LIMIT, 16'h7FFF);
      write_reg(3'd7, 16'h1234);
      sample_queue.push_back({16'd1, 16'h8000, 16'd1000, 16'd0});
      sample_queue.push_back({16'd1, 16'h7FFF, 16'd0, 16'd1000});
      sample_queue.push_back({16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000});
      drain();
      write_reg(cpid_pkg::REG_OUTER_KP, 16'h8000);
      write_reg(cpid_pkg::REG_OUTER_KI, 16'h8000);
      write_reg(cpid_pkg::REG_INNER_KP, 16'h8000);
      write_reg(cpid_pkg::REG_INNER_KI, 16'h8000);
      write_reg(cpid_pkg::REG_INNER_KD, 16'h8000);
      write_reg(cpid_pkg::REG_OUTPUT_LIMIT, 16'd0);
      sample_queue.push_back({16'd3, 16'h7FFF, 16'h8000, 16'h7FFF});
      sample_queue.push_back({16'd0, 16'h8000, 16'h7FFF, 16'h8000});
      drain();
      write_reg(cpid_pkg::REG_OUTPUT_LIMIT, 16'd1);
      sample_queue.push_back({16'd2, 16'h0100, 16'd10, 16'd0});
      drain();

      for (int p = 0; p < 8; p++) begin
         random_gains(p[0] ? 32767 : 3000);
         if (p == 3) quiet = 1'b1;
         phase(230);
         quiet = 1'b0;
      end

      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
